// ----- sv/fmsq_pkg.sv -----
// shared types and codes for the oldest-or-highest serve queue
`default_nettype none
package fmsq_pkg;

  localparam logic [1:0] CMD_ARRIVE  = 2'd0;
  localparam logic [1:0] CMD_OLDEST  = 2'd1;
  localparam logic [1:0] CMD_HIGHEST = 2'd2;

  localparam logic [1:0] STATUS_STORED = 2'd0;
  localparam logic [1:0] STATUS_SERVED = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [1:0] STATUS_FULL   = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

endpackage
`default_nettype wire

// ----- sv/fmsq_ram.sv -----
// generic single-port-write ram with registered read
`default_nettype none
module fmsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/fmsq_cmp.sv -----
// shared candidate-versus-best compare unit used during a table scan
`default_nettype none
module fmsq_cmp #(
  parameter int VALUE_BITS = 16,
  parameter int ID_BITS    = 32
) (
  input  wire logic [1:0]            cmd,
  input  wire logic                  found,
  input  wire logic                  cand_valid,
  input  wire logic [VALUE_BITS-1:0] cand_value,
  input  wire logic [ID_BITS-1:0]    cand_arrival,
  input  wire logic [ID_BITS-1:0]    counter,
  input  wire logic [VALUE_BITS-1:0] best_value,
  input  wire logic [ID_BITS-1:0]    best_age,
  output logic                       take,
  output logic      [ID_BITS-1:0]    cand_age
);
  import fmsq_pkg::*;

  logic older;

  always_comb begin
    cand_age = counter - cand_arrival;
    older    = cand_age > best_age;
    case (cmd)
      CMD_ARRIVE:  take = !cand_valid && !found;
      CMD_OLDEST:  take = cand_valid && (!found || older);
      CMD_HIGHEST: take = cand_valid && (!found || (cand_value > best_value) ||
                                         ((cand_value == best_value) && older));
      default:     take = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/fifo_or_max_value_serve_queue.sv -----
// top level: entry table in ram, scan sequencer and result register
//
// channel  dir  handshake            payload
// in_      in   in_valid / in_stall  in_command, in_value
// out_     out  out_valid / out_stall out_served_id, out_status
//
// every request with command 0 to 2 scans all ENTRIES slots through the one
// compare unit, one slot per cycle, then passes a drain and a commit state;
// the result is registered in commit, and the next request is taken once commit is done
// after reset a clearing pass writes all ENTRIES slots before the first request
// code 3 requests are taken without a scan and give no result
// a result waiting on out_stall holds the next request in its commit state
`default_nettype none
module fifo_or_max_value_serve_queue #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 16,
  parameter int ID_BITS    = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_command,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [31:0]           out_served_id,
  output logic      [1:0]            out_status
);
  import fmsq_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int WW = 1 + VALUE_BITS + ID_BITS;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  state_t state_r, state_nxt;
  logic [AW-1:0]         addr_r;
  logic [AW-1:0]         rd_idx_r;
  logic                  rd_pend_r;
  logic [1:0]            cmd_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  found_r;
  logic [AW-1:0]         best_idx_r;
  logic [ID_BITS-1:0]    best_age_r;
  logic [VALUE_BITS-1:0] best_val_r;
  logic [ID_BITS-1:0]    best_arr_r;
  logic [ID_BITS-1:0]    ctr_r;
  logic                  out_valid_r;
  logic [31:0]           out_served_id_r;
  logic [1:0]            out_status_r;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WW-1:0]         ram_wdata;
  logic [WW-1:0]         ram_rdata;
  logic                  take;
  logic [ID_BITS-1:0]    cand_age;
  logic                  in_go;
  logic                  commit_go;
  logic [ID_BITS+31:0]   arr_ext;

  fmsq_ram #(
    .WIDTH (WW),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  fmsq_cmp #(
    .VALUE_BITS (VALUE_BITS),
    .ID_BITS    (ID_BITS)
  ) u_cmp (
    .cmd          (cmd_r),
    .found        (found_r),
    .cand_valid   (ram_rdata[WW-1]),
    .cand_value   (ram_rdata[ID_BITS +: VALUE_BITS]),
    .cand_arrival (ram_rdata[ID_BITS-1:0]),
    .counter      (ctr_r),
    .best_value   (best_val_r),
    .best_age     (best_age_r),
    .take         (take),
    .cand_age     (cand_age)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_go     = in_valid && (state_r == S_IDLE);
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);
  assign arr_ext   = {32'd0, best_arr_r};

  assign out_valid     = out_valid_r;
  assign out_served_id = out_served_id_r;
  assign out_status    = out_status_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (addr_r == LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && (in_command inside {CMD_ARRIVE, CMD_OLDEST, CMD_HIGHEST})) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (addr_r == LAST) state_nxt = S_DRAIN;
      end
      S_DRAIN: state_nxt = S_COMMIT;
      S_COMMIT: begin
        if (commit_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = '0;
    case (state_r)
      S_CLEAR: ram_we = 1'b1;
      S_COMMIT: begin
        ram_waddr = best_idx_r;
        ram_we    = commit_go && found_r;
        if (cmd_r == CMD_ARRIVE) begin
          ram_wdata = {1'b1, val_r, ctr_r + ID_BITS'(1)};
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      rd_pend_r   <= 1'b0;
      found_r     <= 1'b0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == S_SCAN);
      if (state_r == S_CLEAR || state_r == S_SCAN) begin
        addr_r <= (addr_r == LAST) ? '0 : addr_r + AW'(1);
      end
      if (in_go) begin
        found_r <= 1'b0;
      end else if (rd_pend_r && take) begin
        found_r <= 1'b1;
      end
      if (commit_go) begin
        out_valid_r <= 1'b1;
        if (cmd_r == CMD_ARRIVE && found_r) ctr_r <= ctr_r + ID_BITS'(1);
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= addr_r;
    if (in_go) begin
      cmd_r <= in_command;
      val_r <= in_value;
    end
    if (rd_pend_r && take) begin
      best_idx_r <= rd_idx_r;
      best_age_r <= cand_age;
      best_val_r <= ram_rdata[ID_BITS +: VALUE_BITS];
      best_arr_r <= ram_rdata[ID_BITS-1:0];
    end
    if (commit_go) begin
      if (cmd_r == CMD_ARRIVE) begin
        out_status_r    <= found_r ? STATUS_STORED : STATUS_FULL;
        out_served_id_r <= '0;
      end else if (found_r) begin
        out_status_r    <= STATUS_SERVED;
        out_served_id_r <= arr_ext[31:0];
      end else begin
        out_status_r    <= STATUS_EMPTY;
        out_served_id_r <= '0;
      end
    end
  end

  a_cmp_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> $past(state_r) == S_SCAN)
    else $error("compare slot without a read issued in scan");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_COMMIT)
    else $error("result raised outside commit");

  a_id_only_when_served: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STATUS_SERVED) |-> out_served_id_r == 32'd0)
    else $error("nonzero id on a result that served nothing");

  a_counter_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (ctr_r != $past(ctr_r)) |-> (ctr_r == $past(ctr_r) + ID_BITS'(1)))
    else $error("arrival counter moved by more than one");

endmodule
`default_nettype wire
